[rtl/core/mbrtu_pkg.sv]
package mbrtu_pkg;

	localparam int unsigned CfgIdxW = 1;
	localparam int unsigned CfgDataW = 8;
	localparam logic [15:0] CrcInit = 16'hFFFF;
	localparam logic [15:0] CrcPoly = 16'hA001;
	localparam logic [8:0] MinFrameLen = 9'd3;

	typedef enum logic [1:0] {
		KIND_BYTE    = 2'd0,
		KIND_TICK    = 2'd1,
		KIND_RELEASE = 2'd2,
		KIND_READ    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		MODE_WAIT  = 2'd0,
		MODE_RECV  = 2'd1,
		MODE_READY = 2'd2
	} mode_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_DEVICE_ADDRESS  = 1'd0,
		CFG_FRAME_GAP_TICKS = 1'd1
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0] status;
		logic [8:0] frame_length;
		logic [7:0] read_data;
		logic       frame_rejected;
	} result_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CrcPoly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

[rtl/core/mbrtu_if.sv]
interface mbrtu_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] read_index;

	modport source(output valid, kind, data_byte, read_index, input ready);
	modport sink(input valid, kind, data_byte, read_index, output ready);
endinterface

interface mbrtu_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] status;
	logic [8:0] frame_length;
	logic [7:0] read_data;
	logic       frame_rejected;

	modport source(output valid, status, frame_length, read_data, frame_rejected, input ready);
	modport sink(input valid, status, frame_length, read_data, frame_rejected, output ready);
endinterface

[rtl/core/modbus_rtu_frame_receiver.sv]
// A result word is registered in the frame controller and again in the output stage.
// Throughput: one input word per cycle while the result side keeps taking words;
// the frame store write, its registered read and the CRC byte step all happen in the same cycle.
// Reset (arst_n low) returns to waiting for the address with an empty frame and
// restores device address 1 and gap limit 4; the frame store itself is not cleared.
module modbus_rtu_frame_receiver #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbrtu_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [mbrtu_pkg::CfgDataW-1:0] cfg_wdata,
	mbrtu_in_if.sink                       item_in,
	mbrtu_out_if.source                    result_out
);

	logic               res_valid;
	logic               res_ready;
	mbrtu_pkg::result_t res;

	mbrtu_frame_ctl #(
		.STORE_DEPTH(STORE_DEPTH)
	) u_frame_ctl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_valid(item_in.valid),
		.in_ready(item_in.ready),
		.kind(item_in.kind),
		.data_byte(item_in.data_byte),
		.read_index(item_in.read_index),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res)
	);

	mbrtu_out_stage u_out_stage (
		.clk(clk),
		.arst_n(arst_n),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res(res),
		.result_out(result_out)
	);

endmodule

[rtl/core/mbrtu_frame_ctl.sv]
module mbrtu_frame_ctl #(
	parameter int unsigned STORE_DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [mbrtu_pkg::CfgIdxW-1:0]     cfg_index,
	input  logic [mbrtu_pkg::CfgDataW-1:0]    cfg_wdata,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        kind,
	input  logic [7:0]                        data_byte,
	input  logic [7:0]                        read_index,
	output logic                              res_valid,
	input  logic                              res_ready,
	output mbrtu_pkg::result_t                res
);

	localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
	localparam logic [8:0] DepthC = 9'(STORE_DEPTH);

	logic [7:0]  store [STORE_DEPTH];

	logic [7:0]  dev_addr_q;
	logic [7:0]  gap_ticks_q;
	logic [1:0]  mode_q;
	logic [8:0]  count_q;
	logic [7:0]  gap_q;
	logic [15:0] crc_q;
	logic [15:0] prior_q;

	logic        valid_s1;
	logic [1:0]  status_s1;
	logic [8:0]  len_s1;
	logic        rd_en_s1;
	logic [7:0]  rd_s1;
	logic        rej_s1;

	logic        accept;
	logic [1:0]  cur_mode, nxt_mode;
	logic [8:0]  cur_count, nxt_count;
	logic [7:0]  cur_gap, nxt_gap;
	logic [15:0] cur_crc, nxt_crc;
	logic [15:0] cur_prior, nxt_prior;
	logic        wr_en;
	logic        rejected;
	logic        rd_en;
	logic [8:0]  gap_inc;
	logic        good;

	assign accept = in_valid && in_ready;
	assign in_ready = !valid_s1 || res_ready;

	always_comb begin
		if (mode_q == mbrtu_pkg::MODE_WAIT || mode_q == mbrtu_pkg::MODE_RECV
				|| mode_q == mbrtu_pkg::MODE_READY) begin
			cur_mode = mode_q;
			cur_count = count_q;
			cur_gap = gap_q;
			cur_crc = crc_q;
			cur_prior = prior_q;
		end else begin
			cur_mode = mbrtu_pkg::MODE_WAIT;
			cur_count = '0;
			cur_gap = '0;
			cur_crc = mbrtu_pkg::CrcInit;
			cur_prior = '0;
		end
	end

	always_comb begin
		nxt_mode = cur_mode;
		nxt_count = cur_count;
		nxt_gap = cur_gap;
		nxt_crc = cur_crc;
		nxt_prior = cur_prior;
		wr_en = 1'b0;
		rejected = 1'b0;
		rd_en = 1'b0;
		gap_inc = {1'b0, cur_gap} + 9'd1;
		good = (cur_count >= mbrtu_pkg::MinFrameLen)
			&& (cur_crc[7:0] == cur_prior[15:8])
			&& (cur_crc[15:8] == cur_prior[7:0]);
		case (kind)
			mbrtu_pkg::KIND_BYTE: begin
				if ((cur_mode == mbrtu_pkg::MODE_WAIT && data_byte == dev_addr_q)
						|| (cur_mode == mbrtu_pkg::MODE_RECV && cur_count < DepthC)) begin
					if (cur_count >= 9'd2) begin
						nxt_crc = mbrtu_pkg::crc_byte(cur_crc, cur_prior[15:8]);
					end
					nxt_prior = {cur_prior[7:0], data_byte};
					wr_en = 1'b1;
					nxt_count = cur_count + 9'd1;
					nxt_gap = '0;
					nxt_mode = mbrtu_pkg::MODE_RECV;
				end else if (cur_mode == mbrtu_pkg::MODE_RECV) begin
					nxt_mode = mbrtu_pkg::MODE_WAIT;
					nxt_count = '0;
					nxt_gap = '0;
					nxt_crc = mbrtu_pkg::CrcInit;
					nxt_prior = '0;
					rejected = 1'b1;
				end
			end
			mbrtu_pkg::KIND_TICK: begin
				if (cur_mode == mbrtu_pkg::MODE_RECV) begin
					if (gap_inc > {1'b0, gap_ticks_q}) begin
						if (good) begin
							nxt_mode = mbrtu_pkg::MODE_READY;
							nxt_gap = '0;
						end else begin
							nxt_mode = mbrtu_pkg::MODE_WAIT;
							nxt_count = '0;
							nxt_gap = '0;
							nxt_crc = mbrtu_pkg::CrcInit;
							nxt_prior = '0;
							rejected = 1'b1;
						end
					end else begin
						nxt_gap = gap_inc[7:0];
					end
				end
			end
			mbrtu_pkg::KIND_RELEASE: begin
				nxt_mode = mbrtu_pkg::MODE_WAIT;
				nxt_count = '0;
				nxt_gap = '0;
				nxt_crc = mbrtu_pkg::CrcInit;
				nxt_prior = '0;
			end
			default: begin
				rd_en = ({1'b0, read_index} < cur_count) && ({1'b0, read_index} < DepthC);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && wr_en) begin
			store[cur_count[AW-1:0]] <= data_byte;
		end
		if (accept) begin
			rd_s1 <= store[read_index[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= 8'd1;
			gap_ticks_q <= 8'd4;
			mode_q <= mbrtu_pkg::MODE_WAIT;
			count_q <= '0;
			gap_q <= '0;
			crc_q <= mbrtu_pkg::CrcInit;
			prior_q <= '0;
			valid_s1 <= 1'b0;
			status_s1 <= mbrtu_pkg::MODE_WAIT;
			len_s1 <= '0;
			rd_en_s1 <= 1'b0;
			rej_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					mbrtu_pkg::CFG_DEVICE_ADDRESS: dev_addr_q <= cfg_wdata;
					mbrtu_pkg::CFG_FRAME_GAP_TICKS: gap_ticks_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (accept) begin
				mode_q <= nxt_mode;
				count_q <= nxt_count;
				gap_q <= nxt_gap;
				crc_q <= nxt_crc;
				prior_q <= nxt_prior;
				status_s1 <= nxt_mode;
				len_s1 <= nxt_count;
				rd_en_s1 <= rd_en;
				rej_s1 <= rejected;
				valid_s1 <= 1'b1;
			end else if (res_ready) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	assign res_valid = valid_s1;
	assign res.status = status_s1;
	assign res.frame_length = len_s1;
	assign res.read_data = rd_en_s1 ? rd_s1 : 8'h00;
	assign res.frame_rejected = rej_s1;

endmodule

[rtl/core/mbrtu_out_stage.sv]
module mbrtu_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               res_valid,
	output logic               res_ready,
	input  mbrtu_pkg::result_t res,
	mbrtu_out_if.source        result_out
);

	logic               valid_q;
	mbrtu_pkg::result_t data_q;

	assign res_ready = !valid_q || result_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_ready) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			data_q <= res;
		end
	end

	assign result_out.valid = valid_q;
	assign result_out.status = data_q.status;
	assign result_out.frame_length = data_q.frame_length;
	assign result_out.read_data = data_q.read_data;
	assign result_out.frame_rejected = data_q.frame_rejected;

endmodule

[rtl/core/mbrtu_checker.sv]
module mbrtu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [1:0] status,
	input logic [8:0] frame_length,
	input logic [7:0] read_data,
	input logic       frame_rejected
);

	// A rejected frame always leaves the receiver empty and waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frame_rejected |-> status == mbrtu_pkg::MODE_WAIT && frame_length == 9'd0)
		else $error("rejection did not clear the frame");

	// Nothing is stored while waiting for the address.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mbrtu_pkg::MODE_WAIT |-> frame_length == 9'd0 && read_data == 8'h00)
		else $error("bytes held while waiting for address");

	// A frame only becomes ready with at least the address and the two CRC bytes.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == mbrtu_pkg::MODE_READY |-> frame_length >= mbrtu_pkg::MinFrameLen)
		else $error("ready frame shorter than minimum");

	// A stalled result word holds.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(frame_length)
			&& $stable(read_data) && $stable(frame_rejected))
		else $error("stalled result word changed");

endmodule

bind modbus_rtu_frame_receiver mbrtu_checker u_mbrtu_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(result_out.valid),
	.out_ready(result_out.ready),
	.status(result_out.status),
	.frame_length(result_out.frame_length),
	.read_data(result_out.read_data),
	.frame_rejected(result_out.frame_rejected)
);

[test/tb_modbus_rtu_frame_receiver.sv]
`timescale 1ns / 100ps

module tb_modbus_rtu_frame_receiver;

	localparam int STORE_DEPTH = 64;
	localparam int STALL_LIMIT = 4000;
	localparam int HOLD_CYCLES = 300;

	class frame_scoreboard;
		logic [7:0]           station;
		logic [7:0]           gap_limit;
		mbrtu_pkg::mode_t     mode;
		logic [8:0]           count;
		logic [7:0]           store [STORE_DEPTH];
		logic [7:0]           idle_ticks;
		logic [15:0]          crc;
		logic [15:0]          last_two;
		mbrtu_pkg::result_t   expected_q [$];
		int unsigned mismatches;
		int unsigned checked;
		int unsigned frames_good;
		int unsigned frames_bad;
		int unsigned reads;
		int unsigned used_words;

		function new();
			station = 8'h01;
			gap_limit = 8'd4;
			foreach (store[i]) begin
				store[i] = 8'h00;
			end
			mismatches = 0;
			checked = 0;
			frames_good = 0;
			frames_bad = 0;
			reads = 0;
			used_words = 0;
			clear();
		endfunction

		static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] b);
			logic [15:0] r;
			r = c ^ {8'h00, b};
			for (int n = 0; n < 8; n++) begin
				r = {1'b0, r[15:1]} ^ (r[0] ? 16'hA001 : 16'h0000);
			end
			return r;
		endfunction

		function void clear();
			mode = mbrtu_pkg::MODE_WAIT;
			count = '0;
			idle_ticks = '0;
			crc = 16'hFFFF;
			last_two = '0;
		endfunction

		// The CRC trails the incoming bytes by two, so the two newest bytes are the checksum.
		function void push(logic [7:0] b);
			if (count >= 2) begin
				crc = crc_next(crc, last_two[15:8]);
			end
			last_two = {last_two[7:0], b};
			store[count] = b;
			count = count + 9'd1;
			idle_ticks = '0;
		endfunction

		function void set_register(mbrtu_pkg::cfg_idx_t idx, logic [7:0] v);
			case (idx)
				mbrtu_pkg::CFG_DEVICE_ADDRESS: begin
					station = v;
				end
				default: begin
					gap_limit = v;
				end
			endcase
		endfunction

		function void note_input(mbrtu_pkg::kind_t k, logic [7:0] d, logic [7:0] idx);
			mbrtu_pkg::result_t r;
			bit used;
			int next_ticks;
			r = '0;
			used = 1;
			case (k)
				mbrtu_pkg::KIND_BYTE: begin
					if (mode == mbrtu_pkg::MODE_WAIT) begin
						if (d == station) begin
							push(d);
							mode = mbrtu_pkg::MODE_RECV;
						end else begin
							used = 0;
						end
					end else if (mode == mbrtu_pkg::MODE_RECV) begin
						if (count >= STORE_DEPTH) begin
							clear();
							r.frame_rejected = 1'b1;
						end else begin
							push(d);
						end
					end else begin
						used = 0;
					end
				end
				mbrtu_pkg::KIND_TICK: begin
					if (mode == mbrtu_pkg::MODE_RECV) begin
						next_ticks = int'(idle_ticks) + 1;
						if (next_ticks > int'(gap_limit)) begin
							if (count >= 3 && crc[7:0] == last_two[15:8] &&
									crc[15:8] == last_two[7:0]) begin
								mode = mbrtu_pkg::MODE_READY;
								idle_ticks = '0;
								frames_good++;
							end else begin
								clear();
								r.frame_rejected = 1'b1;
							end
						end else begin
							idle_ticks = 8'(next_ticks);
						end
					end else begin
						used = 0;
					end
				end
				mbrtu_pkg::KIND_RELEASE: begin
					clear();
				end
				default: begin
					if (idx < count && idx < STORE_DEPTH) begin
						r.read_data = store[idx];
					end
					reads++;
				end
			endcase
			if (r.frame_rejected) begin
				frames_bad++;
			end
			r.status = mode;
			r.frame_length = count;
			expected_q.push_back(r);
			if (used) begin
				used_words++;
			end
		endfunction

		function void check_result(mbrtu_pkg::result_t got);
			mbrtu_pkg::result_t want;
			checked++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Unexpected result word: status %0d length %0d",
						got.status, got.frame_length,
						" data %02h rejected %0b", got.read_data, got.frame_rejected);
				end
				return;
			end
			want = expected_q.pop_front();
			if (got.status !== want.status || got.frame_length !== want.frame_length ||
					got.read_data !== want.read_data ||
					got.frame_rejected !== want.frame_rejected) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Mismatch at result %0d: expected status %0d length %0d",
						checked, want.status, want.frame_length,
						" data %02h rejected %0b,", want.read_data, want.frame_rejected,
						" got status %0d length %0d", got.status, got.frame_length,
						" data %02h rejected %0b", got.read_data, got.frame_rejected);
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [mbrtu_pkg::CfgIdxW-1:0] cfg_index;
	logic [mbrtu_pkg::CfgDataW-1:0] cfg_wdata;

	mbrtu_in_if  in_ch ();
	mbrtu_out_if out_ch ();

	modbus_rtu_frame_receiver #(
		.STORE_DEPTH(STORE_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.item_in(in_ch),
		.result_out(out_ch)
	);

	frame_scoreboard sb = new();
	logic [7:0] frame_buf [$];
	logic [7:0] cur_addr;
	int cur_gap;
	int send_idle_pct;
	int recv_idle_pct;
	bit hold_request;
	int stall_cycles;
	int settings_done;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		mbrtu_pkg::result_t got;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				sb.note_input(mbrtu_pkg::kind_t'(in_ch.kind), in_ch.data_byte,
					in_ch.read_index);
			end
			if (out_ch.valid && out_ch.ready) begin
				got.status = out_ch.status;
				got.frame_length = out_ch.frame_length;
				got.read_data = out_ch.read_data;
				got.frame_rejected = out_ch.frame_rejected;
				sb.check_result(got);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no word accepted for %0d cycles", STALL_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 0;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_word(mbrtu_pkg::kind_t k, logic [7:0] d, logic [7:0] idx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.kind <= k;
		in_ch.data_byte <= d;
		in_ch.read_index <= idx;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
	endtask

	task automatic send_byte(logic [7:0] d);
		send_word(mbrtu_pkg::KIND_BYTE, d, 8'($urandom));
	endtask

	task automatic send_tick();
		send_word(mbrtu_pkg::KIND_TICK, 8'($urandom), 8'($urandom));
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_tick();
	endtask

	task automatic send_read(int idx);
		send_word(mbrtu_pkg::KIND_READ, 8'($urandom), 8'(idx));
	endtask

	task automatic send_release();
		send_word(mbrtu_pkg::KIND_RELEASE, 8'($urandom), 8'($urandom));
	endtask

	task automatic append_crc();
		logic [15:0] c;
		c = 16'hFFFF;
		foreach (frame_buf[i]) begin
			c = frame_scoreboard::crc_next(c, frame_buf[i]);
		end
		frame_buf.push_back(c[7:0]);
		frame_buf.push_back(c[15:8]);
	endtask

	task automatic make_good(int total);
		frame_buf = {};
		frame_buf.push_back(cur_addr);
		repeat (total - 3) frame_buf.push_back(8'($urandom));
		append_crc();
	endtask

	task automatic send_frame(bit plain);
		foreach (frame_buf[i]) begin
			send_byte(frame_buf[i]);
			if (!plain) begin
				if ($urandom_range(7) == 0) begin
					send_read($urandom_range(0, i));
				end
				if ($urandom_range(3) == 0 && i + 1 < frame_buf.size()) begin
					send_ticks($urandom_range(0, cur_gap <= 8 ? cur_gap : 2));
				end
			end
		end
	endtask

	task automatic end_frame();
		send_ticks(cur_gap + 1);
	endtask

	task automatic serve_ready(int len);
		repeat ($urandom_range(2, 6)) begin
			case ($urandom_range(4))
				0, 1: send_read($urandom_range(0, len - 1));
				2: send_read($urandom_range(255));
				3: send_byte(8'($urandom));
				default: send_tick();
			endcase
		end
		send_read(len - 1);
		send_read(len);
		send_release();
	endtask

	task automatic run_sequence(int sel);
		int k;
		logic [7:0] stray;
		if ($urandom_range(3) == 0) begin
			stray = 8'($urandom);
			if (stray == cur_addr) begin
				stray = stray ^ 8'h01;
			end
			send_byte(stray);
		end
		if (sel < 45) begin
			make_good($urandom_range(3, 10));
			send_frame(0);
			end_frame();
			serve_ready(frame_buf.size());
		end else if (sel < 60) begin
			make_good($urandom_range(3, 12));
			k = $urandom_range(1, frame_buf.size() - 1);
			frame_buf[k] = frame_buf[k] ^ (8'h01 << $urandom_range(7));
			send_frame(0);
			end_frame();
		end else if (sel < 68) begin
			frame_buf = {};
			frame_buf.push_back(cur_addr);
			if ($urandom_range(1) == 1) begin
				frame_buf.push_back(8'($urandom));
			end
			send_frame(0);
			end_frame();
		end else if (sel < 72) begin
			make_good(STORE_DEPTH);
			send_frame(0);
			end_frame();
			serve_ready(STORE_DEPTH);
		end else if (sel < 76) begin
			// One byte past a full store drops the whole frame.
			frame_buf = {};
			frame_buf.push_back(cur_addr);
			repeat (STORE_DEPTH) frame_buf.push_back(8'($urandom));
			send_frame(0);
			send_release();
		end else if (sel < 84) begin
			make_good($urandom_range(4, 12));
			k = $urandom_range(1, frame_buf.size() - 1);
			while (frame_buf.size() > k) void'(frame_buf.pop_back());
			send_frame(0);
			send_release();
		end else begin
			repeat ($urandom_range(1, 6)) begin
				send_word(mbrtu_pkg::kind_t'($urandom_range(3)),
					($urandom_range(3) == 0) ? cur_addr : 8'($urandom), 8'($urandom));
			end
			send_release();
		end
	endtask

	task automatic write_registers(logic [7:0] addr, int gap);
		cfg_we <= 1'b1;
		cfg_index <= mbrtu_pkg::CFG_DEVICE_ADDRESS;
		cfg_wdata <= addr;
		@(posedge clk);
		cfg_index <= mbrtu_pkg::CFG_FRAME_GAP_TICKS;
		cfg_wdata <= 8'(gap);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_register(mbrtu_pkg::CFG_DEVICE_ADDRESS, addr);
		sb.set_register(mbrtu_pkg::CFG_FRAME_GAP_TICKS, 8'(gap));
		cur_addr = addr;
		cur_gap = gap;
		settings_done++;
	endtask

	task automatic drain(int settle);
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		int start;
		logic [7:0] addr;
		int gap;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mbrtu_pkg::CFG_DEVICE_ADDRESS;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.kind <= mbrtu_pkg::KIND_BYTE;
		in_ch.data_byte <= '0;
		in_ch.read_index <= '0;
		hold_request = 0;
		stall_cycles = 0;
		settings_done = 0;
		cur_addr = 8'h01;
		cur_gap = 4;
		send_idle_pct = 25;
		recv_idle_pct = 71;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset values: address 1, gap limit 4.
		send_tick();
		send_byte(8'h00);
		send_read(0);
		send_release();
		frame_buf = {};
		frame_buf.push_back(8'h01);
		frame_buf.push_back(8'hFF);
		append_crc();
		send_frame(1);
		send_ticks(5);
		send_read(0);
		send_read(3);
		send_read(255);
		send_byte(8'hFF);
		send_tick();
		send_release();
		send_byte(8'h01);
		send_ticks(5);

		for (int phase = 0; phase < 5; phase++) begin
			drain(4);
			case (phase)
				0: begin
					addr = 8'h00;
					gap = 1;
				end
				1: begin
					addr = 8'hFF;
					gap = 2;
				end
				2: begin
					addr = 8'($urandom);
					gap = 3;
				end
				3: begin
					addr = 8'h5A;
					gap = 255;
				end
				default: begin
					addr = 8'($urandom);
					gap = $urandom_range(1, 8);
				end
			endcase
			send_idle_pct = (phase < 2) ? 25 : (phase < 4) ? 71 : 0;
			recv_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 25 : 0;
			write_registers(addr, gap);
			if (phase == 1) begin
				hold_request = 1;
			end
			if (gap == 255) begin
				run_sequence(0);
				run_sequence(50);
			end else begin
				start = sb.used_words;
				while (sb.used_words - start < 120) run_sequence($urandom_range(99));
			end
		end

		drain(10);
		$display("Covered %0d register settings and %0d input words", settings_done,
			sb.used_words, " that changed state or read the store.");
		$display("Checked %0d result words: %0d frames accepted, %0d rejected,",
			sb.checked, sb.frames_good, sb.frames_bad, " %0d store reads.", sb.reads);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[modbus_rtu_frame_receiver.f]
rtl/core/mbrtu_pkg.sv
rtl/core/mbrtu_if.sv
rtl/core/mbrtu_frame_ctl.sv
rtl/core/mbrtu_out_stage.sv
rtl/core/modbus_rtu_frame_receiver.sv
rtl/core/mbrtu_checker.sv
test/tb_modbus_rtu_frame_receiver.sv
